### sv/msk_pkg.sv
// Shared types and codes for the minimum-tracking stack.
package msk_pkg;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  // Input word: one operation.
  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  // Result word: stack view after the operation.
  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [1:0]                status;
  } out_word_t;

  // One stored stack entry: the value and the minimum of it and all entries below.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] run_min;
  } entry_t;

endpackage

### sv/msk_store.sv
// Entry memory of the stack: one write port, one registered read port.
module msk_store #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  msk_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output msk_pkg::entry_t          rd_data
);
  import msk_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/min_tracking_stack.sv
// Top level of the minimum-tracking stack: control, cached top entry and result register.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | msk_pkg::in_word_t  (mode, push_value)
//   out_    | output    | out_valid/out_stall | msk_pkg::out_word_t (top, min, count, status)
//
// A push or query has its result registered at the accepting edge.
// A pop that leaves at least one entry passes through S_FETCH: the entry below the top is
// read from the entry memory's registered read port and then registered as the result.
// Reset empties the stack and drops any pending result; memory contents stay undefined.
// A stalled result holds in the output register; a new word is taken in the same
// cycle that the waiting result leaves.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msk_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output msk_pkg::out_word_t out_data
);
  import msk_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);
  localparam logic [CW-1:0] TWO_CNT  = CW'(2);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [VALUE_W-1:0] top_val_r, top_val_nxt;
  logic signed [VALUE_W-1:0] top_min_r, top_min_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_data_r, out_data_nxt;

  logic                      accept;
  logic                      out_free;
  logic                      is_empty;
  logic                      is_full;
  logic signed [VALUE_W-1:0] run_min_new;
  logic [CW-1:0]             below_idx;

  logic                      wr_en;
  entry_t                    wr_data;
  logic                      rd_en;
  entry_t                    rd_data;

  // Builds a result word; an empty stack shows zero for top and minimum.
  function automatic out_word_t pack_out(logic signed [VALUE_W-1:0] t,
                                         logic signed [VALUE_W-1:0] m,
                                         logic [CW-1:0] c,
                                         logic [1:0] s);
    logic [CW+COUNT_W-1:0] wide;
    out_word_t             w;
    wide          = {{COUNT_W{1'b0}}, c};
    w.top_value   = (c != '0) ? t : '0;
    w.min_value   = (c != '0) ? m : '0;
    w.entry_count = wide[COUNT_W-1:0];
    w.status      = s;
    return w;
  endfunction

  // Handshake: one word at a time, taken only while the result register can load.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == FULL_CNT);
  assign run_min_new = (!is_empty && (top_min_r < in_data.push_value)) ?
                       top_min_r : in_data.push_value;
  assign below_idx   = count_r - TWO_CNT;

  // Memory access: a push writes the new top, a deep pop fetches the entry below.
  assign wr_en           = accept && (in_data.mode == MODE_PUSH) && !is_full;
  assign wr_data.value   = in_data.push_value;
  assign wr_data.run_min = run_min_new;
  assign rd_en           = accept && (in_data.mode == MODE_POP) && (count_r > ONE_CNT);

  msk_store #(
    .DEPTH(STACK_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(below_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  // Operation sequencing and next-state logic.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_min_nxt   = top_min_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_data_nxt = pack_out(top_val_r, top_min_r, count_r, ST_PUSH_FULL);
              end else begin
                count_nxt    = count_r + ONE_CNT;
                top_val_nxt  = in_data.push_value;
                top_min_nxt  = run_min_new;
                out_data_nxt = pack_out(in_data.push_value, run_min_new,
                                        count_r + ONE_CNT, ST_OK);
              end
            end
            MODE_POP: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = pack_out(top_val_r, top_min_r, count_r, ST_POP_EMPTY);
              end else if (count_r == ONE_CNT) begin
                count_nxt     = '0;
                out_valid_nxt = 1'b1;
                out_data_nxt  = pack_out(top_val_r, top_min_r, '0, ST_OK);
              end else begin
                count_nxt = count_r - ONE_CNT;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pack_out(top_val_r, top_min_r, count_r, ST_OK);
            end
          endcase
        end
      end
      S_FETCH: begin
        // The entry below the old top has arrived and becomes the new top.
        top_val_nxt   = rd_data.value;
        top_min_nxt   = rd_data.run_min;
        out_valid_nxt = 1'b1;
        out_data_nxt  = pack_out(rd_data.value, rd_data.run_min, count_r, ST_OK);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: cached top entry and the result word.
  always_ff @(posedge clk) begin
    top_val_r  <= top_val_nxt;
    top_min_r  <= top_min_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/msk_check.sv
// Port-level checks for the minimum-tracking stack, bound to the top level.
module msk_check #(
  parameter int STACK_DEPTH = 256
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input msk_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input msk_pkg::out_word_t out_data
);
  import msk_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // The minimum never exceeds the top of a non-empty stack.
  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.entry_count != '0) |-> out_data.min_value <= out_data.top_value)
    else $error("minimum above top value");

  // An empty stack shows zero for top and minimum, and never a push-full status.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (STACK_DEPTH < 512) && (out_data.entry_count == '0) |->
    (out_data.top_value == '0) && (out_data.min_value == '0) &&
    (out_data.status != ST_PUSH_FULL))
    else $error("empty stack shows nonzero data or a full status");

  // A pop on an empty stack leaves the count at zero.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (STACK_DEPTH < 512) && (out_data.status == ST_POP_EMPTY) |->
    (out_data.entry_count == '0))
    else $error("pop-empty status with entries held");

endmodule

bind min_tracking_stack msk_check #(.STACK_DEPTH(STACK_DEPTH)) u_msk_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### bench/min_tracking_stack_checker.sv
// Checker for the minimum-tracking stack: predicts every result word and compares it.
module min_tracking_stack_checker #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  msk_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  msk_pkg::out_word_t out_data,
  input  logic               drain_done,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 full_drops,
  output int                 empty_pops,
  output int                 peak_depth
);
  import msk_pkg::*;

  // Shadow copy of the stack: each entry keeps its value and the minimum at or below it.
  logic signed [VALUE_W-1:0] held_value [STACK_DEPTH];
  logic signed [VALUE_W-1:0] held_min [STACK_DEPTH];
  int depth = 0;
  out_word_t expected_views[$];
  bit leftovers_checked = 1'b0;

  initial begin
    fail_count = 0;
    pending = 0;
    results_checked = 0;
    full_drops = 0;
    empty_pops = 0;
    peak_depth = 0;
  end

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch at result %0d: %s", results_checked, what);
  endtask

  // Apply one operation word to the shadow stack and return the view after it.
  function automatic out_word_t apply_op(input in_word_t w);
    out_word_t view;
    logic signed [VALUE_W-1:0] floor_min;
    view = '0;
    view.status = ST_OK;
    case (w.mode)
      MODE_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          view.status = ST_PUSH_FULL;
        end else begin
          floor_min = w.push_value;
          if (depth > 0 && $signed(held_min[depth-1]) < $signed(w.push_value)) begin
            floor_min = held_min[depth-1];
          end
          held_value[depth] = w.push_value;
          held_min[depth] = floor_min;
          depth++;
        end
      end
      MODE_POP: begin
        if (depth == 0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          depth--;
        end
      end
      // A query, or the spare mode code, leaves the stack alone.
      default: ;
    endcase
    if (depth > 0) begin
      view.top_value = held_value[depth-1];
      view.min_value = held_min[depth-1];
    end
    view.entry_count = COUNT_W'(depth);
    return view;
  endfunction

  // Watch both channels at each edge; results are checked before new words are predicted.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      depth = 0;
      expected_views.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_views.pop_front();
          if (out_data.top_value !== want.top_value) begin
            report_mismatch($sformatf("top_value got %0d expected %0d",
                                      out_data.top_value, want.top_value));
          end
          if (out_data.min_value !== want.min_value) begin
            report_mismatch($sformatf("min_value got %0d expected %0d",
                                      out_data.min_value, want.min_value));
          end
          if (out_data.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_data.entry_count, want.entry_count));
          end
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_data.status, want.status));
          end
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        want = apply_op(in_data);
        expected_views = {expected_views, want};
        if (want.status == ST_PUSH_FULL) full_drops++;
        if (want.status == ST_POP_EMPTY) empty_pops++;
        if (depth > peak_depth) peak_depth = depth;
      end
      // Once the stimulus side says the run is over, anything still queued is lost.
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_views.size() != 0) begin
          report_mismatch($sformatf("%0d expected result words never arrived",
                                    expected_views.size()));
        end
      end
    end
    pending = expected_views.size();
  end

endmodule

### bench/min_tracking_stack_test.sv
// Testbench top for the minimum-tracking stack: clock, reset, stimulus, stalls and verdict.
module min_tracking_stack_test;
  import msk_pkg::*;

  localparam int DEPTH = 256;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD = 300;
  // The mode code with no operation of its own; the block treats it as a query.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic drain_done = 1'b0;

  int fail_count;
  int pending;
  int results_checked;
  int full_drops;
  int empty_pops;
  int peak_depth;
  int words_sent = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  min_tracking_stack_checker #(
    .STACK_DEPTH(DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .drain_done     (drain_done),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .full_drops     (full_drops),
    .empty_pops     (empty_pops),
    .peak_depth     (peak_depth)
  );

  always #1 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Push values lean on the extremes and on a narrow band so equal values repeat.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      4, 5: return VALUE_W'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Offer one word until it is taken, then maybe pause between bursts.
  task automatic offer(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value);
    int idle;
    in_valid <= 1'b1;
    in_data <= '{mode: mode, push_value: value};
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // A run of random words; push_pct sets how hard the run leans toward filling the stack.
  task automatic run_segment(input int count, input int push_pct);
    int roll;
    logic [1:0] mode;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        mode = MODE_SPARE;
      end else if (roll < 10) begin
        mode = MODE_QUERY;
      end else if (roll < 10 + push_pct * 90 / 100) begin
        mode = MODE_PUSH;
      end else begin
        mode = MODE_POP;
      end
      offer(mode, pick_value());
    end
  endtask

  // Receiver: mixed stall patterns, plus two long hold-offs that back the block up.
  initial begin : stall_pattern
    int style;
    int stretch;
    int holds_done;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ((holds_done == 0 && words_sent >= 40) || (holds_done == 1 && words_sent >= 900)) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        style = $urandom_range(0, 3);
        stretch = $urandom_range(4, 60);
        repeat (stretch) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Sender: reset, directed words, random segments, then drain and verdict.
  initial begin : stimulus
    int push_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack: query, pop on empty and the spare mode code.
    offer(MODE_QUERY, 32'sd17);
    offer(MODE_POP, 32'sd0);
    offer(MODE_SPARE, 32'sd5);
    // Extremes of the value range, then unwind past empty.
    offer(MODE_PUSH, 32'sh7FFF_FFFF);
    offer(MODE_PUSH, 32'sh8000_0000);
    offer(MODE_PUSH, 32'sd0);
    offer(MODE_PUSH, -32'sd1);
    offer(MODE_QUERY, 32'sd0);
    repeat (4) offer(MODE_POP, 32'sd0);
    offer(MODE_POP, 32'sd0);
    // Equal minimums stacked twice, so popping one copy keeps the other.
    offer(MODE_PUSH, 32'sd10);
    offer(MODE_PUSH, 32'sd3);
    offer(MODE_PUSH, 32'sd7);
    offer(MODE_PUSH, 32'sd3);
    offer(MODE_POP, 32'sd0);
    offer(MODE_POP, 32'sd0);
    offer(MODE_PUSH, -32'sd5);
    offer(MODE_QUERY, 32'sd0);
    repeat (3) offer(MODE_POP, 32'sd0);

    // Fill well past full, then drain well past empty.
    run_segment(320, 100);
    run_segment(320, 0);
    // Then runs of random length and random lean.
    while (words_sent < RANDOM_WORDS + 24) begin
      case ($urandom_range(0, 4))
        0: push_pct = 85;
        1: push_pct = 60;
        2: push_pct = 50;
        3: push_pct = 40;
        default: push_pct = 15;
      endcase
      run_segment($urandom_range(20, 150), push_pct);
    end
    in_valid <= 1'b0;

    // Wait out the outstanding results, then a few idle cycles.
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d words and checked %0d results; the stack peaked at %0d of %0d entries.",
             words_sent, results_checked, peak_depth, DEPTH);
    $display("Saw %0d pushes dropped on a full stack and %0d pops ignored on an empty one.",
             full_drops, empty_pops);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
